>>> sv/pbcm_pkg.sv
`timescale 1ns / 1ps

package pbcm_pkg;

  // Field widths
  localparam int PT_W          = 16;  // point and result coordinates
  localparam int CFG_W         = 16;  // basis vector components
  localparam int FRAC_BITS_DEF = 12;

  // Configuration register map
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FROM_U_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FROM_U_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FROM_V_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FROM_V_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TO_U_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TO_U_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TO_V_X   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TO_V_Y   = 3'd7;

  // Datapath widths
  localparam int PROD_W = 2 * PT_W;      // 16x16 product
  localparam int DET_W  = PROD_W + 1;    // det, na, nb
  localparam int MUL_W  = DET_W + CFG_W; // na * to_*
  localparam int NUM_W  = MUL_W + 1;     // numerator per axis
  localparam int NN_W   = NUM_W + 1;     // 2|num| + |det|
  localparam int DEN_W  = DET_W + 1;     // 2|det|
  localparam int Q_W    = PT_W + 1;      // quotient bits resolved by the cell row
  localparam int N_CELLS = Q_W;
  localparam int N_LANES = 2;            // x and y

  // Saturation limits on the quotient magnitude
  localparam logic [Q_W-1:0] POS_LIM = Q_W'((2 ** (PT_W - 1)) - 1);
  localparam logic [Q_W-1:0] NEG_LIM = Q_W'(2 ** (PT_W - 1));
  localparam logic [PT_W-1:0] SAT_MAX = {1'b0, {(PT_W - 1){1'b1}}};
  localparam logic [PT_W-1:0] SAT_MIN = {1'b1, {(PT_W - 1){1'b0}}};

  typedef struct packed {
    logic signed [CFG_W-1:0] from_u_x;
    logic signed [CFG_W-1:0] from_u_y;
    logic signed [CFG_W-1:0] from_v_x;
    logic signed [CFG_W-1:0] from_v_y;
    logic signed [CFG_W-1:0] to_u_x;
    logic signed [CFG_W-1:0] to_u_y;
    logic signed [CFG_W-1:0] to_v_x;
    logic signed [CFG_W-1:0] to_v_y;
  } cfg_t;

  // One axis of the long division in flight
  typedef struct packed {
    logic [DEN_W-1:0] rem;   // partial remainder, < den unless ovf
    logic [Q_W-1:0]   lo;    // dividend bits not yet shifted in
    logic [Q_W-1:0]   quot;  // quotient bits so far
    logic             ovf;   // quotient known to exceed Q_W bits
    logic             neg;   // result sign
  } div_lane_t;

  typedef struct packed {
    logic                     valid;
    logic                     degen;
    logic [DEN_W-1:0]         den;
    div_lane_t [N_LANES-1:0]  lane;
  } div_stage_t;

endpackage

>>> sv/pbcm_front.sv
`timescale 1ns / 1ps

module pbcm_front import pbcm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [PT_W-1:0]  point_x_i,
  input  logic [PT_W-1:0]  point_y_i,
  input  cfg_t             cfg_i,
  output div_stage_t       s_o
);

  logic signed [PT_W-1:0] px, py;
  assign px = point_x_i;
  assign py = point_y_i;

  // valid per stage A..F
  logic [5:0] v_q;

  // A: products
  logic signed [PROD_W-1:0] a_xfvy_q, a_yfvx_q, a_yfux_q, a_xfuy_q, a_d0_q, a_d1_q;
  // B: na, nb, det
  logic signed [DET_W-1:0]  b_na_q, b_nb_q, b_det_q;
  // C: products with the target basis
  logic signed [MUL_W-1:0]  c_ax_q, c_bx_q, c_ay_q, c_by_q;
  logic signed [DET_W-1:0]  c_det_q;
  // D: numerators
  logic signed [NUM_W-1:0]  d_numx_q, d_numy_q;
  logic signed [DET_W-1:0]  d_det_q;
  // E: magnitudes and signs
  logic [NUM_W-1:0]         e_magx_q, e_magy_q;
  logic [DET_W-1:0]         e_mdet_q;
  logic                     e_negx_q, e_negy_q, e_degen_q;
  // F: rounded dividends and divisor
  logic [NN_W-1:0]          f_nx_q, f_ny_q;
  logic [DEN_W-1:0]         f_den_q;
  logic                     f_negx_q, f_negy_q, f_degen_q;

  div_stage_t g_d, g_q;
  logic [NN_W-1:0] seed_x, seed_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_xfvy_q <= PROD_W'(px) * PROD_W'(cfg_i.from_v_y);
      a_yfvx_q <= PROD_W'(py) * PROD_W'(cfg_i.from_v_x);
      a_yfux_q <= PROD_W'(py) * PROD_W'(cfg_i.from_u_x);
      a_xfuy_q <= PROD_W'(px) * PROD_W'(cfg_i.from_u_y);
      a_d0_q   <= PROD_W'(cfg_i.from_u_x) * PROD_W'(cfg_i.from_v_y);
      a_d1_q   <= PROD_W'(cfg_i.from_u_y) * PROD_W'(cfg_i.from_v_x);

      b_na_q   <= DET_W'(a_xfvy_q) - DET_W'(a_yfvx_q);
      b_nb_q   <= DET_W'(a_yfux_q) - DET_W'(a_xfuy_q);
      b_det_q  <= DET_W'(a_d0_q) - DET_W'(a_d1_q);

      c_ax_q   <= MUL_W'(b_na_q) * MUL_W'(cfg_i.to_u_x);
      c_bx_q   <= MUL_W'(b_nb_q) * MUL_W'(cfg_i.to_v_x);
      c_ay_q   <= MUL_W'(b_na_q) * MUL_W'(cfg_i.to_u_y);
      c_by_q   <= MUL_W'(b_nb_q) * MUL_W'(cfg_i.to_v_y);
      c_det_q  <= b_det_q;

      d_numx_q <= NUM_W'(c_ax_q) + NUM_W'(c_bx_q);
      d_numy_q <= NUM_W'(c_ay_q) + NUM_W'(c_by_q);
      d_det_q  <= c_det_q;

      e_magx_q  <= d_numx_q[NUM_W-1] ? $unsigned(-d_numx_q) : $unsigned(d_numx_q);
      e_magy_q  <= d_numy_q[NUM_W-1] ? $unsigned(-d_numy_q) : $unsigned(d_numy_q);
      e_mdet_q  <= d_det_q[DET_W-1] ? $unsigned(-d_det_q) : $unsigned(d_det_q);
      e_negx_q  <= d_numx_q[NUM_W-1] ^ d_det_q[DET_W-1];
      e_negy_q  <= d_numy_q[NUM_W-1] ^ d_det_q[DET_W-1];
      e_degen_q <= (d_det_q == '0);

      // round to nearest: (2n + d) / (2d)
      f_nx_q    <= {e_magx_q, 1'b0} + NN_W'(e_mdet_q);
      f_ny_q    <= {e_magy_q, 1'b0} + NN_W'(e_mdet_q);
      f_den_q   <= {e_mdet_q, 1'b0};
      f_negx_q  <= e_negx_q;
      f_negy_q  <= e_negy_q;
      f_degen_q <= e_degen_q;
    end
  end

  // G: seed the division; upper dividend bits become the first remainder
  assign seed_x = f_nx_q >> Q_W;
  assign seed_y = f_ny_q >> Q_W;

  always_comb begin
    g_d.valid        = v_q[5];
    g_d.degen        = f_degen_q;
    g_d.den          = f_den_q;
    g_d.lane[0].rem  = DEN_W'(seed_x);
    g_d.lane[0].lo   = f_nx_q[Q_W-1:0];
    g_d.lane[0].quot = '0;
    g_d.lane[0].ovf  = (seed_x >= NN_W'(f_den_q));
    g_d.lane[0].neg  = f_negx_q;
    g_d.lane[1].rem  = DEN_W'(seed_y);
    g_d.lane[1].lo   = f_ny_q[Q_W-1:0];
    g_d.lane[1].quot = '0;
    g_d.lane[1].ovf  = (seed_y >= NN_W'(f_den_q));
    g_d.lane[1].neg  = f_negy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_q <= '0;
    end else if (en_i) begin
      g_q <= g_d;
    end
  end

  assign s_o = g_q;

endmodule

>>> sv/pbcm_div_cell.sv
`timescale 1ns / 1ps

// One restoring-division step for both axes: shift in one dividend bit,
// subtract the divisor if it fits, emit one quotient bit.
module pbcm_div_cell import pbcm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  div_stage_t  s_i,
  output div_stage_t  s_o
);

  div_stage_t s_d, s_q;
  logic [DEN_W:0] trial [N_LANES];
  logic           fits  [N_LANES];

  always_comb begin
    s_d = s_i;
    for (int l = 0; l < N_LANES; l++) begin
      trial[l] = {s_i.lane[l].rem, s_i.lane[l].lo[Q_W-1]};
      fits[l]  = (trial[l] >= {1'b0, s_i.den});
      s_d.lane[l].rem  = fits[l] ? DEN_W'(trial[l] - {1'b0, s_i.den})
                                 : trial[l][DEN_W-1:0];
      s_d.lane[l].lo   = {s_i.lane[l].lo[Q_W-2:0], 1'b0};
      s_d.lane[l].quot = {s_i.lane[l].quot[Q_W-2:0], fits[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '0;
    end else if (en_i) begin
      s_q <= s_d;
    end
  end

  assign s_o = s_q;

  // x-lane remainder stays below the divisor for any valid, non-degenerate item that is in range
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_q.valid && !s_q.degen && !s_q.lane[0].ovf |-> s_q.lane[0].rem < s_q.den)
    else $error("x remainder not below divisor");

endmodule

>>> sv/pbcm_out.sv
`timescale 1ns / 1ps

// Sign, saturation and degenerate zeroing, output register and one-entry skid buffer.
module pbcm_out import pbcm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_stage_t       s_i,
  output logic             en_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [PT_W-1:0]  mapped_x_o,
  output logic [PT_W-1:0]  mapped_y_o,
  output logic             degenerate_o
);

  typedef struct packed {
    logic [PT_W-1:0] mx;
    logic [PT_W-1:0] my;
    logic            degen;
  } res_t;

  function automatic logic [PT_W-1:0] sat_lane(div_lane_t l, logic degen);
    logic [Q_W-1:0]  nq;
    logic [PT_W-1:0] r;
    nq = ~l.quot + 1'b1;
    if (degen) begin
      r = '0;
    end else if (l.neg) begin
      r = (l.ovf || l.quot > NEG_LIM) ? SAT_MIN : nq[PT_W-1:0];
    end else begin
      r = (l.ovf || l.quot > POS_LIM) ? SAT_MAX : l.quot[PT_W-1:0];
    end
    return r;
  endfunction

  res_t res, out_q, skid_q;
  logic out_v_q, skid_v_q;
  logic take, push;

  assign res.mx    = sat_lane(s_i.lane[0], s_i.degen);
  assign res.my    = sat_lane(s_i.lane[1], s_i.degen);
  assign res.degen = s_i.degen;

  assign en_o = !skid_v_q;
  assign take = out_v_q && !out_stall_i;
  assign push = en_o && s_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || take) begin
      out_v_q  <= skid_v_q || push;
      skid_v_q <= 1'b0;
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || take) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign out_valid_o  = out_v_q;
  assign mapped_x_o   = out_q.mx;
  assign mapped_y_o   = out_q.my;
  assign degenerate_o = out_q.degen;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a transfer while output register is empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && out_stall_i))
    else $error("skid filled without a stalled output");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && degenerate_o |-> mapped_x_o == '0 && mapped_y_o == '0)
    else $error("degenerate result with nonzero coordinates");

endmodule

>>> sv/planar_basis_change_map.sv
`timescale 1ns / 1ps

// Channel   Valid        Stall        Payload
// input     in_valid_i   in_stall_o   point_x_i, point_y_i
// output    out_valid_o  out_stall_i  mapped_x_o, mapped_y_o, degenerate_o
// config    cfg_we_i     -            cfg_idx_i, cfg_wdata_i
//
// One point per cycle when not stalled; 25 register stages from input transfer
// to the earliest output transfer (7 front stages, 17 division cells, 1 output
// register). The division cell row sets the latency: one quotient bit per cell.
// Reset restores the basis registers to identity and empties the pipeline.
// A stalled output first fills a one-entry skid; only then does the whole
// pipeline, and with it in_stall_o, hold.
module planar_basis_change_map import pbcm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // point input
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PT_W-1:0]      point_x_i,
  input  logic [PT_W-1:0]      point_y_i,
  // mapped output
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PT_W-1:0]      mapped_x_o,
  output logic [PT_W-1:0]      mapped_y_o,
  output logic                 degenerate_o,
  // basis register writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  // 1.0 in the configured fixed-point format, truncated to register width
  localparam logic [CFG_W-1:0] CFG_ONE = CFG_W'(1 << FRAC_BITS);

  cfg_t       cfg_q;
  logic       en;
  div_stage_t chain [N_CELLS+1];

  // Basis registers. Users write them only while the pipeline is drained
  // (unenforced), so stages read them directly without snapshotting per point.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.from_u_x <= CFG_ONE;
      cfg_q.from_u_y <= '0;
      cfg_q.from_v_x <= '0;
      cfg_q.from_v_y <= CFG_ONE;
      cfg_q.to_u_x   <= CFG_ONE;
      cfg_q.to_u_y   <= '0;
      cfg_q.to_v_x   <= '0;
      cfg_q.to_v_y   <= CFG_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FROM_U_X: cfg_q.from_u_x <= cfg_wdata_i;
        CFG_FROM_U_Y: cfg_q.from_u_y <= cfg_wdata_i;
        CFG_FROM_V_X: cfg_q.from_v_x <= cfg_wdata_i;
        CFG_FROM_V_Y: cfg_q.from_v_y <= cfg_wdata_i;
        CFG_TO_U_X:   cfg_q.to_u_x   <= cfg_wdata_i;
        CFG_TO_U_Y:   cfg_q.to_u_y   <= cfg_wdata_i;
        CFG_TO_V_X:   cfg_q.to_v_x   <= cfg_wdata_i;
        CFG_TO_V_Y:   cfg_q.to_v_y   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Whole pipeline advances together unless the skid entry is occupied.
  assign in_stall_o = !en;

  // Products, Cramer numerators, per-axis sums, sign/magnitude split,
  // round-to-nearest bias and division seed with overflow detect.
  pbcm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .cfg_i     (cfg_q),
    .s_o       (chain[0])
  );

  // Row of division cells; each resolves one quotient bit for x and y and
  // hands remainder, remaining dividend bits and quotient to the next.
  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    pbcm_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .s_i    (chain[k]),
      .s_o    (chain[k+1])
    );
  end

  // Saturation to 16 bits, degenerate override, output register and skid.
  pbcm_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_i          (chain[N_CELLS]),
    .en_o         (en),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .mapped_x_o   (mapped_x_o),
    .mapped_y_o   (mapped_y_o),
    .degenerate_o (degenerate_o)
  );

endmodule
